// ===== rtl/tcp_rx_pkg.sv =====
package tcp_rx_pkg;

    // Table and field sizes.
    localparam int OOO_DEPTH = 8;
    localparam int TAG_BITS  = 8;
    localparam int IDX_W     = (OOO_DEPTH > 1) ? $clog2(OOO_DEPTH) : 1;
    localparam int CNT_W     = $clog2(OOO_DEPTH + 1);
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_OPEN      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SEGMENT_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_NEXT_SEQ = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [15:0] WINDOW_RESET = 16'd65535;
    localparam logic [15:0] MSS_RESET    = 16'd536;
    localparam logic [31:0] NEXT_RESET   = 32'd0;

    // Result action codes.
    typedef enum logic [2:0] {
        ACT_DELIVER = 3'd0,
        ACT_ACK     = 3'd1,
        ACT_DELACK  = 3'd2,
        ACT_WDROP   = 3'd3,
        ACT_DUP     = 3'd4,
        ACT_OVERLAP = 3'd5,
        ACT_FULL    = 3'd6
    } action_t;

    // One stored out-of-order segment.
    typedef struct packed {
        logic [31:0]         seq;
        logic [15:0]         length;
        logic [TAG_BITS-1:0] tag;
    } ooo_entry_t;

    localparam int ENTRY_W = $bits(ooo_entry_t);

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_DRAIN_RD,
        ST_DRAIN_CHK,
        ST_SHD_RD,
        ST_SHD_WR,
        ST_ACK_DEC,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_INS_FULL,
        ST_SHU_RD,
        ST_SHU_WR,
        ST_DROP,
        ST_ACK_NOW
    } state_t;

endpackage

// ===== rtl/tcp_rx_if.sv =====
// Segment descriptor channel.
interface tcp_rx_seg_if;
    logic                          valid;
    logic                          ready;
    logic [31:0]                   seg_seq;
    logic [15:0]                   seg_length;
    logic                          push_flag;
    logic [tcp_rx_pkg::TAG_BITS-1:0] buffer_tag;

    modport source (output valid, seg_seq, seg_length, push_flag, buffer_tag, input ready);
    modport sink (input valid, seg_seq, seg_length, push_flag, buffer_tag, output ready);
endinterface

// Result channel.
interface tcp_rx_res_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    action;
    logic [tcp_rx_pkg::TAG_BITS-1:0] out_tag;
    logic [31:0]                   out_seq;
    logic [15:0]                   out_length;
    logic                          last;

    modport source (output valid, action, out_tag, out_seq, out_length, last, input ready);
    modport sink (input valid, action, out_tag, out_seq, out_length, last, output ready);
endinterface

// Configuration write channel.
interface tcp_rx_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [tcp_rx_pkg::CFG_IDX_W-1:0] index;
    logic [31:0]                      data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/tcp_rx_ram.sv =====
// Simple dual-port RAM with one write port and one registered read port.
module tcp_rx_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 56,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/tcp_receive_reassembly.sv =====
// TCP receive reassembly with delayed ack.
// The seg channel takes one segment descriptor per item; the res channel returns
// one to ten result items per segment, the final one flagged by last. The cfg
// channel writes window_open, max_segment_size and initial_next_seq; the user
// must write them only while the block is idle, which the block itself does not
// enforce. A write of initial_next_seq also loads the expected sequence.
// Out-of-order segments sit in an eight-entry table held in a single-port-read
// RAM, kept sorted by sequence. Every insert, lookup and removal walks that RAM
// one entry per access, so the RAM port sets the rate. A segment is taken
// only while the controller is idle. The first result of an in-order or
// window-dropped segment is loaded from the classify state once the output
// register is free; for an out-of-order segment it follows the table scan. An
// in-order segment then drains each head entry that fits, moving the remaining
// entries down after each removal, until the table is empty or the head does
// not fit; an out-of-order one scans entries and moves later ones up to insert.
// A result waits in an output register while res.ready is low; the controller
// stalls on the next result only, and a new segment may be accepted while the
// final result still waits. Reset empties the table, clears the full-segment
// count and restores the register reset values. cfg.ready is always high.
module tcp_receive_reassembly (
    input logic          clk,
    input logic          rst_n,
    tcp_rx_seg_if.sink   seg,
    tcp_rx_res_if.source res,
    tcp_rx_cfg_if.sink   cfg
);

    localparam int CW = tcp_rx_pkg::CNT_W;
    localparam int IW = tcp_rx_pkg::IDX_W;
    localparam int TW = tcp_rx_pkg::TAG_BITS;

    tcp_rx_pkg::state_t state_reg, state_next;

    logic [15:0]   window_reg, window_next;
    logic [15:0]   mss_reg, mss_next;
    logic [31:0]   nes_reg, nes_next;
    logic [CW-1:0] count_reg, count_next;
    logic [1:0]    fsc_reg, fsc_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] pos_reg, pos_next;
    tcp_rx_pkg::action_t err_reg, err_next;

    logic [31:0]   sseq_reg;
    logic [15:0]   slen_reg;
    logic          spsh_reg;
    logic [TW-1:0] stag_reg;

    logic          ovalid_reg, ovalid_next;
    logic [2:0]    oact_reg, oact_next;
    logic [TW-1:0] otag_reg, otag_next;
    logic [31:0]   oseq_reg, oseq_next;
    logic [15:0]   olen_reg, olen_next;
    logic          olast_reg, olast_next;

    logic                   mem_we, mem_re;
    logic [IW-1:0]          mem_waddr, mem_raddr;
    tcp_rx_pkg::ooo_entry_t mem_wdata, mem_rdata;
    logic [tcp_rx_pkg::ENTRY_W-1:0] mem_rbits;

    logic        seg_acc, slot_free, cfg_acc;
    logic [31:0] seg_end;
    logic        head_fits, seg_lt, seg_eq, seg_ovl, force_ack;
    logic [1:0]  fsc_inc;

    tcp_rx_ram #(
        .DEPTH (tcp_rx_pkg::OOO_DEPTH),
        .WIDTH (tcp_rx_pkg::ENTRY_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rbits)
    );

    // Shared conditions.
    assign mem_rdata = tcp_rx_pkg::ooo_entry_t'(mem_rbits);
    assign seg.ready = (state_reg == tcp_rx_pkg::ST_IDLE);
    assign seg_acc   = seg.valid && seg.ready;
    assign cfg.ready = 1'b1;
    assign cfg_acc   = cfg.valid;
    assign slot_free = !ovalid_reg || res.ready;
    assign seg_end   = sseq_reg + {16'd0, slen_reg};
    assign head_fits = (mem_rdata.seq == nes_reg);
    assign seg_lt    = (sseq_reg < mem_rdata.seq);
    assign seg_eq    = (sseq_reg == mem_rdata.seq);
    assign seg_ovl   = (seg_end > mem_rdata.seq);
    assign fsc_inc   = fsc_reg + 2'd1;
    assign force_ack = spsh_reg || ((slen_reg == mss_reg) && (fsc_inc > 2'd1));

    // Result port.
    assign res.valid      = ovalid_reg;
    assign res.action     = oact_reg;
    assign res.out_tag    = otag_reg;
    assign res.out_seq    = oseq_reg;
    assign res.out_length = olen_reg;
    assign res.last       = olast_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tcp_rx_pkg::ST_IDLE:
                if (seg_acc) state_next = tcp_rx_pkg::ST_CLASSIFY;
            tcp_rx_pkg::ST_CLASSIFY:
                if (window_reg == 16'd0)
                begin
                    if (slot_free) state_next = tcp_rx_pkg::ST_IDLE;
                end
                else if (sseq_reg == nes_reg)
                begin
                    if (slot_free) state_next = tcp_rx_pkg::ST_DRAIN_RD;
                end
                else
                begin
                    state_next = tcp_rx_pkg::ST_SCAN_RD;
                end
            tcp_rx_pkg::ST_DRAIN_RD:
                state_next = (count_reg == '0) ? tcp_rx_pkg::ST_ACK_DEC
                                               : tcp_rx_pkg::ST_DRAIN_CHK;
            tcp_rx_pkg::ST_DRAIN_CHK:
                if (!head_fits) state_next = tcp_rx_pkg::ST_ACK_DEC;
                else if (slot_free) state_next = tcp_rx_pkg::ST_SHD_RD;
            tcp_rx_pkg::ST_SHD_RD:
                state_next = (idx_reg < count_reg) ? tcp_rx_pkg::ST_SHD_WR
                                                   : tcp_rx_pkg::ST_DRAIN_RD;
            tcp_rx_pkg::ST_SHD_WR:
                state_next = tcp_rx_pkg::ST_SHD_RD;
            tcp_rx_pkg::ST_ACK_DEC:
                if (slot_free) state_next = tcp_rx_pkg::ST_IDLE;
            tcp_rx_pkg::ST_SCAN_RD:
                state_next = (idx_reg < count_reg) ? tcp_rx_pkg::ST_SCAN_CHK
                                                   : tcp_rx_pkg::ST_INS_FULL;
            tcp_rx_pkg::ST_SCAN_CHK:
                if (seg_lt) state_next = seg_ovl ? tcp_rx_pkg::ST_DROP
                                                 : tcp_rx_pkg::ST_INS_FULL;
                else if (seg_eq) state_next = tcp_rx_pkg::ST_DROP;
                else state_next = tcp_rx_pkg::ST_SCAN_RD;
            tcp_rx_pkg::ST_INS_FULL:
                state_next = (count_reg >= CW'(tcp_rx_pkg::OOO_DEPTH))
                             ? tcp_rx_pkg::ST_DROP : tcp_rx_pkg::ST_SHU_RD;
            tcp_rx_pkg::ST_SHU_RD:
                state_next = (idx_reg > pos_reg) ? tcp_rx_pkg::ST_SHU_WR
                                                 : tcp_rx_pkg::ST_ACK_NOW;
            tcp_rx_pkg::ST_SHU_WR:
                state_next = tcp_rx_pkg::ST_SHU_RD;
            tcp_rx_pkg::ST_DROP:
                if (slot_free) state_next = tcp_rx_pkg::ST_ACK_NOW;
            tcp_rx_pkg::ST_ACK_NOW:
                if (slot_free) state_next = tcp_rx_pkg::ST_IDLE;
            default:
                state_next = tcp_rx_pkg::ST_IDLE;
        endcase
    end

    // Datapath, memory controls and result loading.
    always_comb
    begin
        window_next = window_reg;
        mss_next    = mss_reg;
        nes_next    = nes_reg;
        count_next  = count_reg;
        fsc_next    = fsc_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        err_next    = err_reg;
        ovalid_next = ovalid_reg && !res.ready;
        oact_next   = oact_reg;
        otag_next   = otag_reg;
        oseq_next   = oseq_reg;
        olen_next   = olen_reg;
        olast_next  = olast_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = '0;
        mem_raddr   = '0;
        mem_wdata   = mem_rdata;

        // Configuration writes.
        if (cfg_acc)
        begin
            case (cfg.index)
                tcp_rx_pkg::REG_WINDOW_OPEN:      window_next = cfg.data[15:0];
                tcp_rx_pkg::REG_MAX_SEGMENT_SIZE: mss_next = cfg.data[15:0];
                tcp_rx_pkg::REG_INITIAL_NEXT_SEQ: nes_next = cfg.data;
                default: ;
            endcase
        end

        case (state_reg)
            tcp_rx_pkg::ST_CLASSIFY:
                if (slot_free && (window_reg == 16'd0 || sseq_reg == nes_reg))
                begin
                    ovalid_next = 1'b1;
                    otag_next   = stag_reg;
                    oseq_next   = sseq_reg;
                    olen_next   = slen_reg;
                    if (window_reg == 16'd0)
                    begin
                        oact_next  = tcp_rx_pkg::ACT_WDROP;
                        olast_next = 1'b1;
                    end
                    else
                    begin
                        oact_next  = tcp_rx_pkg::ACT_DELIVER;
                        olast_next = 1'b0;
                        nes_next   = nes_reg + {16'd0, slen_reg};
                    end
                end
                else
                begin
                    idx_next = '0;
                    pos_next = count_reg;
                end
            tcp_rx_pkg::ST_DRAIN_RD:
                mem_re = (count_reg != '0);
            tcp_rx_pkg::ST_DRAIN_CHK:
                if (head_fits && slot_free)
                begin
                    ovalid_next = 1'b1;
                    oact_next   = tcp_rx_pkg::ACT_DELIVER;
                    otag_next   = mem_rdata.tag;
                    oseq_next   = mem_rdata.seq;
                    olen_next   = mem_rdata.length;
                    olast_next  = 1'b0;
                    nes_next    = nes_reg + {16'd0, mem_rdata.length};
                    idx_next    = CW'(1);
                end
            tcp_rx_pkg::ST_SHD_RD:
                if (idx_reg < count_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg[IW-1:0];
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                end
            tcp_rx_pkg::ST_SHD_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = IW'(idx_reg - CW'(1));
                idx_next  = idx_reg + CW'(1);
            end
            tcp_rx_pkg::ST_ACK_DEC:
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    oact_next   = force_ack ? tcp_rx_pkg::ACT_ACK : tcp_rx_pkg::ACT_DELACK;
                    otag_next   = '0;
                    oseq_next   = nes_reg;
                    olen_next   = '0;
                    olast_next  = 1'b1;
                    if (force_ack) fsc_next = '0;
                    else if (slen_reg == mss_reg) fsc_next = fsc_inc;
                end
            tcp_rx_pkg::ST_SCAN_RD:
                if (idx_reg < count_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg[IW-1:0];
                end
            tcp_rx_pkg::ST_SCAN_CHK:
                if (seg_lt)
                begin
                    err_next = tcp_rx_pkg::ACT_OVERLAP;
                    pos_next = idx_reg;
                end
                else if (seg_eq)
                begin
                    err_next = tcp_rx_pkg::ACT_DUP;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            tcp_rx_pkg::ST_INS_FULL:
            begin
                err_next = tcp_rx_pkg::ACT_FULL;
                idx_next = count_reg;
            end
            tcp_rx_pkg::ST_SHU_RD:
                if (idx_reg > pos_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = IW'(idx_reg - CW'(1));
                end
                else
                begin
                    mem_we           = 1'b1;
                    mem_waddr        = pos_reg[IW-1:0];
                    mem_wdata.seq    = sseq_reg;
                    mem_wdata.length = slen_reg;
                    mem_wdata.tag    = stag_reg;
                    count_next       = count_reg + CW'(1);
                end
            tcp_rx_pkg::ST_SHU_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[IW-1:0];
                idx_next  = idx_reg - CW'(1);
            end
            tcp_rx_pkg::ST_DROP:
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    oact_next   = err_reg;
                    otag_next   = stag_reg;
                    oseq_next   = sseq_reg;
                    olen_next   = slen_reg;
                    olast_next  = 1'b0;
                end
            tcp_rx_pkg::ST_ACK_NOW:
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    oact_next   = tcp_rx_pkg::ACT_ACK;
                    otag_next   = '0;
                    oseq_next   = nes_reg;
                    olen_next   = '0;
                    olast_next  = 1'b1;
                end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tcp_rx_pkg::ST_IDLE;
            window_reg <= tcp_rx_pkg::WINDOW_RESET;
            mss_reg    <= tcp_rx_pkg::MSS_RESET;
            nes_reg    <= tcp_rx_pkg::NEXT_RESET;
            count_reg  <= '0;
            fsc_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            window_reg <= window_next;
            mss_reg    <= mss_next;
            nes_reg    <= nes_next;
            count_reg  <= count_next;
            fsc_reg    <= fsc_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        err_reg   <= err_next;
        oact_reg  <= oact_next;
        otag_reg  <= otag_next;
        oseq_reg  <= oseq_next;
        olen_reg  <= olen_next;
        olast_reg <= olast_next;
        if (seg_acc)
        begin
            sseq_reg <= seg.seg_seq;
            slen_reg <= seg.seg_length;
            spsh_reg <= seg.push_flag;
            stag_reg <= seg.buffer_tag;
        end
    end

endmodule

// ===== rtl/tcp_rx_checker.sv =====
// Port-level checks for the reassembly block.
module tcp_rx_checker (
    input logic          clk,
    input logic          rst_n,
    tcp_rx_seg_if.sink   seg,
    tcp_rx_res_if.source res,
    tcp_rx_cfg_if.sink   cfg
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.ready |=> res.valid)
        else $error("result dropped while stalled");

    // One segment is worked on at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        seg.valid && seg.ready |=> !seg.ready)
        else $error("segment taken while busy");

    // A window drop is always the only result of its segment.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.action == tcp_rx_pkg::ACT_WDROP |-> res.last)
        else $error("window drop not final");

    // Ack results carry no tag and no length, and always end the segment.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.action == tcp_rx_pkg::ACT_ACK ||
                      res.action == tcp_rx_pkg::ACT_DELACK)
        |-> res.last && res.out_tag == '0 && res.out_length == '0)
        else $error("malformed ack result");

endmodule

bind tcp_receive_reassembly tcp_rx_checker u_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .seg   (seg),
    .res   (res),
    .cfg   (cfg)
);

// ===== tb/tcp_rx_checker.sv =====
module tcp_rx_scoreboard (
    input  logic    clk,
    input  logic    rst_n,
    tcp_rx_seg_if   seg,
    tcp_rx_res_if   res,
    tcp_rx_cfg_if   cfg,
    output int      fail_count,
    output int      pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]                      action;
        logic [tcp_rx_pkg::TAG_BITS-1:0] tag;
        logic [31:0]                     seq;
        logic [15:0]                     length;
        logic                            last;
    } rx_result_t;

    // Shadow copy of the registers and of the reassembly state.
    logic [15:0]            window_q;
    logic [15:0]            mss_q;
    logic [31:0]            next_seq_q;
    logic [1:0]             full_cnt_q;
    tcp_rx_pkg::ooo_entry_t table_q[$];
    rx_result_t             expected_q[$];

    function automatic rx_result_t mk(tcp_rx_pkg::action_t a,
                                      logic [tcp_rx_pkg::TAG_BITS-1:0] t,
                                      logic [31:0] s, logic [15:0] l);
        rx_result_t r;
        r.action = a;
        r.tag = t;
        r.seq = s;
        r.length = l;
        r.last = 1'b0;
        return r;
    endfunction

    // Work out the results one segment causes and update the shadow state.
    task automatic reassemble_segment(logic [31:0] s, logic [15:0] l, logic p,
                                      logic [tcp_rx_pkg::TAG_BITS-1:0] t);
        rx_result_t             r[$];
        logic                   force_ack;
        logic [31:0]            seg_end;
        tcp_rx_pkg::action_t    code;
        int                     pos;
        tcp_rx_pkg::ooo_entry_t e;
        force_ack = 1'b0;
        code = tcp_rx_pkg::ACT_DELIVER;
        if (window_q == 16'd0)
        begin
            r.push_back(mk(tcp_rx_pkg::ACT_WDROP, t, s, l));
        end
        else if (s == next_seq_q)
        begin
            next_seq_q = next_seq_q + {16'd0, l};
            r.push_back(mk(tcp_rx_pkg::ACT_DELIVER, t, s, l));
            // Drain the head while it lines up with the next expected sequence.
            while (table_q.size() > 0 && table_q[0].seq == next_seq_q)
            begin
                r.push_back(mk(tcp_rx_pkg::ACT_DELIVER, table_q[0].tag, table_q[0].seq,
                               table_q[0].length));
                next_seq_q = next_seq_q + {16'd0, table_q[0].length};
                void'(table_q.pop_front());
            end
            if (p)
            begin
                force_ack = 1'b1;
            end
            else if (l == mss_q)
            begin
                full_cnt_q = full_cnt_q + 2'd1;
                if (full_cnt_q > 2'd1)
                    force_ack = 1'b1;
            end
            if (force_ack)
            begin
                full_cnt_q = 2'd0;
                r.push_back(mk(tcp_rx_pkg::ACT_ACK, '0, next_seq_q, '0));
            end
            else
            begin
                r.push_back(mk(tcp_rx_pkg::ACT_DELACK, '0, next_seq_q, '0));
            end
        end
        else
        begin
            // Ordered insert with duplicate, overlap and full checks.
            seg_end = s + {16'd0, l};
            pos = table_q.size();
            foreach (table_q[i])
            begin
                if (code == tcp_rx_pkg::ACT_DELIVER && pos == table_q.size())
                begin
                    if (s < table_q[i].seq)
                    begin
                        if (seg_end > table_q[i].seq)
                            code = tcp_rx_pkg::ACT_OVERLAP;
                        else
                            pos = i;
                    end
                    else if (s == table_q[i].seq)
                    begin
                        code = tcp_rx_pkg::ACT_DUP;
                    end
                end
            end
            if (code == tcp_rx_pkg::ACT_DELIVER && table_q.size() >= tcp_rx_pkg::OOO_DEPTH)
                code = tcp_rx_pkg::ACT_FULL;
            if (code == tcp_rx_pkg::ACT_DELIVER)
            begin
                e.seq = s;
                e.length = l;
                e.tag = t;
                table_q.insert(pos, e);
            end
            else
            begin
                r.push_back(mk(code, t, s, l));
            end
            r.push_back(mk(tcp_rx_pkg::ACT_ACK, '0, next_seq_q, '0));
        end
        r[r.size()-1].last = 1'b1;
        foreach (r[i])
            expected_q.push_back(r[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rx_result_t got;
        rx_result_t want;
        if (!rst_n)
        begin
            window_q   = tcp_rx_pkg::WINDOW_RESET;
            mss_q      = tcp_rx_pkg::MSS_RESET;
            next_seq_q = tcp_rx_pkg::NEXT_RESET;
            full_cnt_q = 2'd0;
            table_q.delete();
            expected_q.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            // Compare a result item with the oldest expectation.
            if (res.valid && res.ready)
            begin
                got.action = res.action;
                got.tag = res.out_tag;
                got.seq = res.out_seq;
                got.length = res.out_length;
                got.last = res.last;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result expected none actual %h", $time, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                    begin
                        $display({"%0t: result mismatch expected act=%0d tag=%h seq=%h len=%h",
                                  " last=%b actual act=%0d tag=%h seq=%h len=%h last=%b"},
                                 $time, want.action, want.tag, want.seq, want.length,
                                 want.last, got.action, got.tag, got.seq, got.length,
                                 got.last);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    tcp_rx_pkg::REG_WINDOW_OPEN:      window_q = cfg.data[15:0];
                    tcp_rx_pkg::REG_MAX_SEGMENT_SIZE: mss_q = cfg.data[15:0];
                    tcp_rx_pkg::REG_INITIAL_NEXT_SEQ: next_seq_q = cfg.data;
                    default: ;
                endcase
            end
            if (seg.valid && seg.ready)
                reassemble_segment(seg.seg_seq, seg.seg_length, seg.push_flag, seg.buffer_tag);
            pending <= expected_q.size();
        end
    end
endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_off;
    logic hold_req;
    logic hold_seen;
    logic [31:0] base_seq;
    logic [31:0] cursor;

    tcp_rx_seg_if seg ();
    tcp_rx_res_if res ();
    tcp_rx_cfg_if cfg ();

    tcp_receive_reassembly dut (.clk(clk), .rst_n(rst_n), .seg(seg), .res(res), .cfg(cfg));
    tcp_rx_scoreboard chk (.clk(clk), .rst_n(rst_n), .seg(seg), .res(res), .cfg(cfg),
                           .fail_count(fail_count), .pending(pending));

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Timeout watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver side ready with random stalls and a long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res.ready <= 1'b0;
            hold_off  <= 0;
            hold_seen <= 1'b0;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_off  <= HOLD_CYCLES;
            res.ready <= 1'b0;
        end
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            res.ready <= 1'b0;
        end
        else
        begin
            res.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one segment and wait for its acceptance; valid stays up for a
    // following item unless the sender idles.
    task automatic send_segment(logic [31:0] s, logic [15:0] l, logic p, logic [7:0] t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            seg.valid <= 1'b0;
            @(posedge clk);
        end
        seg.valid <= 1'b1;
        seg.seg_seq <= s;
        seg.seg_length <= l;
        seg.push_flag <= p;
        seg.buffer_tag <= t;
        @(posedge clk);
        while (!seg.ready)
            @(posedge clk);
    endtask

    // Wait until every expected result has arrived and the block is quiet.
    task automatic drain_results();
        seg.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic [tcp_rx_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Random segment: mostly near the expected sequence to fill and drain the table.
    task automatic random_segment();
        logic [31:0] s;
        logic [15:0] l;
        int k;
        k = $urandom_range(99);
        l = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 40));
        if ($urandom_range(9) == 0)
            l = 16'd64;
        if (k < 35)
        begin
            s = cursor;
            cursor = cursor + {16'd0, l};
        end
        else if (k < 85)
        begin
            s = cursor + 32'($urandom_range(1, 12) * 64);
        end
        else
        begin
            s = $urandom;
        end
        send_segment(s, l, ($urandom_range(3) == 0), 8'($urandom));
    endtask

    initial
    begin
        hold_req = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        seg.valid = 1'b0;
        seg.seg_seq = '0;
        seg.seg_length = '0;
        seg.push_flag = 1'b0;
        seg.buffer_tag = '0;
        cfg.valid = 1'b0;
        cfg.index = tcp_rx_pkg::REG_WINDOW_OPEN;
        cfg.data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: in order, forced acks, gaps, duplicate, overlap, drain, extremes.
        send_segment(32'd0, 16'd536, 1'b0, 8'h00);
        send_segment(32'd536, 16'd536, 1'b0, 8'hff);
        send_segment(32'd1072, 16'd0, 1'b1, 8'h11);
        send_segment(32'd2000, 16'd100, 1'b0, 8'h22);
        send_segment(32'd2000, 16'd100, 1'b0, 8'h23);
        send_segment(32'd1900, 16'd200, 1'b0, 8'h24);
        send_segment(32'd1500, 16'd100, 1'b0, 8'h25);
        send_segment(32'hffff_ffff, 16'hffff, 1'b1, 8'h26);
        for (int i = 0; i < 7; i++)
            send_segment(32'd3000 + 32'(i) * 100, 16'd100, 1'b0, 8'(i + 48));
        send_segment(32'd9000, 16'd10, 1'b0, 8'h5a);
        send_segment(32'd1072, 16'd428, 1'b0, 8'h5b);
        drain_results();

        // Closed window, then extreme register values and a fresh sequence start.
        write_reg(tcp_rx_pkg::REG_WINDOW_OPEN, 32'd0);
        send_segment(32'hdead_beef, 16'h1234, 1'b1, 8'haa);
        drain_results();
        write_reg(tcp_rx_pkg::REG_WINDOW_OPEN, 32'd1);
        write_reg(tcp_rx_pkg::REG_MAX_SEGMENT_SIZE, 32'hffff);
        write_reg(tcp_rx_pkg::REG_INITIAL_NEXT_SEQ, 32'hffff_fff0);
        send_segment(32'hffff_fff0, 16'hffff, 1'b0, 8'h01);
        send_segment(32'hffff_ffef, 16'd1, 1'b0, 8'h02);
        drain_results();

        // Random phases with different idling and register settings.
        for (int ph = 0; ph < 4; ph++)
        begin
            base_seq = $urandom;
            write_reg(tcp_rx_pkg::REG_WINDOW_OPEN, 32'($urandom_range(1, 65535)));
            write_reg(tcp_rx_pkg::REG_MAX_SEGMENT_SIZE, (ph == 0) ? 32'd1 : 32'd64);
            write_reg(tcp_rx_pkg::REG_INITIAL_NEXT_SEQ, base_seq);
            cursor = base_seq;
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 20 : 68) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 20 : 68) : 0;
            if (ph == 0)
                hold_req <= ~hold_req;
            for (int i = 0; i < 50; i++)
                random_segment();
            drain_results();
        end

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
